>>> src/obmt_pkg.sv
// Shared types, codes and reset constants of the 1-Wire bus master timing block.
package obmt_pkg;

	// Request type codes carried on the request channel
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_RESET = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// Status codes of a result
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_PRES  = 2'd1;
	localparam logic [1:0] ST_REJECTED = 2'd2;

	// Configuration register indexes
	localparam int NUM_REGS = 8;
	localparam logic [2:0] REG_RESET_LOW     = 3'd0;
	localparam logic [2:0] REG_PRES_SAMPLE   = 3'd1;
	localparam logic [2:0] REG_WRITE_SLOT    = 3'd2;
	localparam logic [2:0] REG_WRITE_ONE_LOW = 3'd3;
	localparam logic [2:0] REG_WRITE_REC     = 3'd4;
	localparam logic [2:0] REG_READ_SLOT     = 3'd5;
	localparam logic [2:0] REG_READ_LOW      = 3'd6;
	localparam logic [2:0] REG_READ_SAMPLE   = 3'd7;

	// Register reset values
	localparam logic [11:0] RST_RESET_LOW     = 12'd480;
	localparam logic [11:0] RST_PRES_SAMPLE   = 12'd70;
	localparam logic [11:0] RST_WRITE_SLOT    = 12'd60;
	localparam logic [11:0] RST_WRITE_ONE_LOW = 12'd6;
	localparam logic [11:0] RST_WRITE_REC     = 12'd10;
	localparam logic [11:0] RST_READ_SLOT     = 12'd70;
	localparam logic [11:0] RST_READ_LOW      = 12'd6;
	localparam logic [11:0] RST_READ_SAMPLE   = 12'd9;

	// Default read recovery length in ticks
	localparam int READ_RECOVERY_TICKS_DEF = 5;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef logic [1:0]  req_type_t;
	typedef logic [7:0]  byte_t;
	typedef logic [11:0] ticks_t;
	typedef logic [2:0]  reg_index_t;
	typedef logic [1:0]  status_t;

	// Classified request handed from front to back
	typedef struct packed {
		logic      is_cmd;
		req_type_t kind;
		byte_t     write_data;
		logic      line_level;
	} item_t;

	// Configuration write handed to the back part
	typedef struct packed {
		logic       en;
		reg_index_t index;
		ticks_t     data;
	} cfg_wr_t;

endpackage

>>> src/obmt_req_if.sv
// Request channel: tick and command items into the bus master.
interface obmt_req_if;
	logic                valid;
	logic                ready;
	obmt_pkg::req_type_t req_type;
	obmt_pkg::byte_t     write_data;
	logic                line_level;

	modport source (output valid, output req_type, output write_data, output line_level,
		input ready);
	modport sink (input valid, input req_type, input write_data, input line_level,
		output ready);
endinterface

>>> src/obmt_res_if.sv
// Result channel: one result per request from the bus master.
interface obmt_res_if;
	logic              valid;
	logic              ready;
	logic              line_low;
	logic              busy_res;
	logic              done_res;
	obmt_pkg::status_t status;
	obmt_pkg::byte_t   read_data;

	modport source (output valid, output line_low, output busy_res, output done_res,
		output status, output read_data, input ready);
	modport sink (input valid, input line_low, input busy_res, input done_res,
		input status, input read_data, output ready);
endinterface

>>> src/obmt_cfg_if.sv
// Configuration write channel: register index and write data.
interface obmt_cfg_if;
	logic                 valid;
	logic                 ready;
	obmt_pkg::reg_index_t index;
	obmt_pkg::ticks_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/obmt_front.sv
// Front part: accepts requests, classifies them and pushes them into the queue.
module obmt_front (
	input  logic            clk,
	input  logic            arst_n,
	obmt_req_if.sink        req,
	output obmt_pkg::item_t push_item,
	output logic            push_valid,
	input  logic            push_ready
);
	import obmt_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	// Accept a new request whenever the stage is empty or drains this cycle
	assign take      = req.valid && req.ready;
	assign req.ready = !valid_s1 || push_ready;

	// Hold the stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Classify the request: ticks advance timing, the rest are commands
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.is_cmd     <= (req.req_type != REQ_TICK);
			item_s1.kind       <= req.req_type;
			item_s1.write_data <= req.write_data;
			item_s1.line_level <= req.line_level;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

>>> src/obmt_queue.sv
// Small request queue between the front and back parts.
module obmt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  obmt_pkg::item_t push_item,
	input  logic            push_valid,
	output logic            push_ready,
	output obmt_pkg::item_t pop_item,
	output logic            pop_valid,
	input  logic            pop_ready
);
	import obmt_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t           slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Store the pushed request
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> src/obmt_back.sv
// Back part: holds the timing registers, runs the bus phases and drives results.
module obmt_back #(
	parameter int READ_RECOVERY_TICKS = obmt_pkg::READ_RECOVERY_TICKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  obmt_pkg::cfg_wr_t cfg_wr,
	input  obmt_pkg::item_t   pop_item,
	input  logic              pop_valid,
	output logic              pop_ready,
	obmt_res_if.source        res
);
	import obmt_pkg::*;

	// Bus phase codes
	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_RST_LOW  = 4'd1;
	localparam logic [3:0] PH_RST_WAIT = 4'd2;
	localparam logic [3:0] PH_RST_REST = 4'd3;
	localparam logic [3:0] PH_W_LOW    = 4'd4;
	localparam logic [3:0] PH_W_HIGH   = 4'd5;
	localparam logic [3:0] PH_W_REC    = 4'd6;
	localparam logic [3:0] PH_R_LOW    = 4'd7;
	localparam logic [3:0] PH_R_WAIT   = 4'd8;
	localparam logic [3:0] PH_R_REST   = 4'd9;
	localparam logic [3:0] PH_R_REC    = 4'd10;

	// Read recovery length, clamped to the 12-bit tick range
	localparam ticks_t READ_REC_LEN = (READ_RECOVERY_TICKS > 4095) ? 12'd4095 :
		((READ_RECOVERY_TICKS < 1) ? 12'd1 : 12'(READ_RECOVERY_TICKS));

	function automatic ticks_t at_least_one(input ticks_t v);
		return (v == '0) ? 12'd1 : v;
	endfunction

	function automatic ticks_t sat_sub(input ticks_t a, input ticks_t b);
		return (a > b) ? (a - b) : 12'd0;
	endfunction

	// Timing registers
	ticks_t cfg_q [NUM_REGS];

	// Phase lengths derived from the timing registers
	ticks_t len_rst_low_q, len_rst_wait_q, len_rst_rest_q;
	ticks_t len_w_one_q, len_w_zero_q, len_w_high_q, len_w_rec_q;
	ticks_t len_r_low_q, len_r_wait_q, len_r_rest_q;

	// Sequence state
	logic [3:0] phase_q;
	ticks_t     tick_q;
	logic [2:0] bit_q;
	byte_t      shift_q;
	req_type_t  kind_q;
	logic       pres_q;

	// Result register
	logic    res_valid_q;
	logic    line_low_q, busy_q, done_q;
	status_t status_q;
	byte_t   rdata_q;

	// Next-state values
	logic [3:0] phase_d;
	ticks_t     tick_d;
	logic [2:0] bit_d;
	byte_t      shift_d;
	req_type_t  kind_d;
	logic       pres_d;
	logic       done_d;
	status_t    status_d;
	byte_t      rdata_d;
	logic       line_low_d;

	ticks_t tick_inc;
	ticks_t cur_len;
	logic   hit;
	logic   ends;
	logic   step;

	assign step      = pop_valid && pop_ready;
	assign pop_ready = !res_valid_q || res.ready;

	// Write timing registers; every 3-bit index names one of the eight registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_RESET_LOW]     <= RST_RESET_LOW;
			cfg_q[REG_PRES_SAMPLE]   <= RST_PRES_SAMPLE;
			cfg_q[REG_WRITE_SLOT]    <= RST_WRITE_SLOT;
			cfg_q[REG_WRITE_ONE_LOW] <= RST_WRITE_ONE_LOW;
			cfg_q[REG_WRITE_REC]     <= RST_WRITE_REC;
			cfg_q[REG_READ_SLOT]     <= RST_READ_SLOT;
			cfg_q[REG_READ_LOW]      <= RST_READ_LOW;
			cfg_q[REG_READ_SAMPLE]   <= RST_READ_SAMPLE;
		end else if (cfg_wr.en) begin
			cfg_q[cfg_wr.index] <= cfg_wr.data;
		end
	end

	// Precompute phase lengths, one register stage after the timing registers
	always_ff @(posedge clk) begin
		len_rst_low_q  <= at_least_one(cfg_q[REG_RESET_LOW]);
		len_rst_wait_q <= at_least_one(cfg_q[REG_PRES_SAMPLE]);
		len_rst_rest_q <= sat_sub(at_least_one(cfg_q[REG_RESET_LOW]),
			at_least_one(cfg_q[REG_PRES_SAMPLE]));
		len_w_one_q    <= at_least_one(cfg_q[REG_WRITE_ONE_LOW]);
		len_w_zero_q   <= at_least_one(cfg_q[REG_WRITE_SLOT]);
		len_w_high_q   <= sat_sub(at_least_one(cfg_q[REG_WRITE_SLOT]),
			at_least_one(cfg_q[REG_WRITE_ONE_LOW]));
		len_w_rec_q    <= at_least_one(cfg_q[REG_WRITE_REC]);
		len_r_low_q    <= at_least_one(cfg_q[REG_READ_LOW]);
		len_r_wait_q   <= at_least_one(cfg_q[REG_READ_SAMPLE]);
		len_r_rest_q   <= sat_sub(sat_sub(at_least_one(cfg_q[REG_READ_SLOT]),
			at_least_one(cfg_q[REG_READ_LOW])), at_least_one(cfg_q[REG_READ_SAMPLE]));
	end

	// Select the length of the running phase
	always_comb begin
		unique case (phase_q)
			PH_RST_LOW:  cur_len = len_rst_low_q;
			PH_RST_WAIT: cur_len = len_rst_wait_q;
			PH_RST_REST: cur_len = len_rst_rest_q;
			PH_W_LOW:    cur_len = shift_q[0] ? len_w_one_q : len_w_zero_q;
			PH_W_HIGH:   cur_len = len_w_high_q;
			PH_W_REC:    cur_len = len_w_rec_q;
			PH_R_LOW:    cur_len = len_r_low_q;
			PH_R_WAIT:   cur_len = len_r_wait_q;
			PH_R_REST:   cur_len = len_r_rest_q;
			PH_R_REC:    cur_len = READ_REC_LEN;
			default:     cur_len = 12'd1;
		endcase
	end

	assign tick_inc = tick_q + 12'd1;
	assign hit      = (tick_inc >= cur_len);

	// Advance the sequence by one request
	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		bit_d      = bit_q;
		shift_d    = shift_q;
		kind_d     = kind_q;
		pres_d     = pres_q;
		ends       = 1'b0;
		done_d     = 1'b0;
		status_d   = ST_OK;
		rdata_d    = '0;

		if (pop_item.is_cmd) begin
			if (phase_q != PH_IDLE) begin
				status_d = ST_REJECTED;
			end else begin
				// Start a new command sequence
				kind_d = pop_item.kind;
				bit_d  = '0;
				pres_d = 1'b0;
				tick_d = '0;
				unique case (pop_item.kind)
					REQ_RESET: begin
						shift_d = '0;
						phase_d = PH_RST_LOW;
					end
					REQ_WRITE: begin
						shift_d = pop_item.write_data;
						phase_d = PH_W_LOW;
					end
					default: begin
						shift_d = '0;
						phase_d = PH_R_LOW;
					end
				endcase
			end
		end else if (phase_q != PH_IDLE) begin
			tick_d = tick_inc;
			if (hit) begin
				tick_d = '0;
				unique case (phase_q)
					PH_RST_LOW:  phase_d = PH_RST_WAIT;
					PH_RST_WAIT: begin
						pres_d = !pop_item.line_level;
						if (len_rst_rest_q != '0) begin
							phase_d = PH_RST_REST;
						end else begin
							ends = 1'b1;
						end
					end
					PH_RST_REST: ends = 1'b1;
					PH_W_LOW: begin
						phase_d = (shift_q[0] && len_w_high_q != '0) ? PH_W_HIGH : PH_W_REC;
					end
					PH_W_HIGH:   phase_d = PH_W_REC;
					PH_W_REC: begin
						shift_d = {1'b0, shift_q[7:1]};
						if (bit_q == 3'd7) begin
							ends = 1'b1;
						end else begin
							bit_d   = bit_q + 3'd1;
							phase_d = PH_W_LOW;
						end
					end
					PH_R_LOW:    phase_d = PH_R_WAIT;
					PH_R_WAIT: begin
						shift_d = {pop_item.line_level, shift_q[7:1]};
						phase_d = (len_r_rest_q != '0) ? PH_R_REST : PH_R_REC;
					end
					PH_R_REST:   phase_d = PH_R_REC;
					PH_R_REC: begin
						if (bit_q == 3'd7) begin
							ends = 1'b1;
						end else begin
							bit_d   = bit_q + 3'd1;
							phase_d = PH_R_LOW;
						end
					end
					default:     ends = 1'b1;
				endcase
				// Finish the sequence and report its outcome
				if (ends) begin
					done_d  = 1'b1;
					phase_d = PH_IDLE;
					tick_d  = '0;
					bit_d   = '0;
					if (kind_q == REQ_RESET) begin
						status_d = pres_d ? ST_OK : ST_NO_PRES;
					end
					if (kind_q == REQ_READ) begin
						rdata_d = shift_d;
					end
				end
			end
		end

		line_low_d = (phase_d == PH_RST_LOW) || (phase_d == PH_W_LOW) ||
			(phase_d == PH_R_LOW);
	end

	// Hold sequence state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			kind_q      <= '0;
			pres_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_d;
				tick_q  <= tick_d;
				bit_q   <= bit_d;
				shift_q <= shift_d;
				kind_q  <= kind_d;
				pres_q  <= pres_d;
			end
			if (pop_ready) begin
				res_valid_q <= pop_valid;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (step) begin
			line_low_q <= line_low_d;
			busy_q     <= (phase_d != PH_IDLE);
			done_q     <= done_d;
			status_q   <= status_d;
			rdata_q    <= rdata_d;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.line_low  = line_low_q;
	assign res.busy_res  = busy_q;
	assign res.done_res  = done_q;
	assign res.status    = status_q;
	assign res.read_data = rdata_q;

endmodule

>>> src/onewire_bus_master_timing.sv
// Top level of the 1-Wire bus master timing block.
//
//   channel  dir  payload                                          handshake
//   req      in   req_type, write_data, line_level                 valid/ready
//   res      out  line_low, busy_res, done_res, status, read_data  valid/ready
//   cfg      in   index, data                                      valid/ready (always ready)
//
// One request is taken per cycle and gives one result; the sustained rate is one
// item per clock while res is ready. Path: front register, queue, result register.
// The per-tick work is one 12-bit increment and compare in the back part.
// Reset clears the sequence state and loads the timing registers with their defaults.
// A stalled result holds in the result register while up to four more requests wait
// in the queue; the request side stalls only once the queue and front stage are full.
module onewire_bus_master_timing #(
	parameter int READ_RECOVERY_TICKS = obmt_pkg::READ_RECOVERY_TICKS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	obmt_req_if.sink req,
	obmt_res_if.source res,
	obmt_cfg_if.sink cfg
);
	import obmt_pkg::*;

	item_t   push_item;
	logic    push_valid;
	logic    push_ready;
	item_t   pop_item;
	logic    pop_valid;
	logic    pop_ready;
	cfg_wr_t cfg_wr;

	// Take configuration writes at any time
	assign cfg.ready    = 1'b1;
	assign cfg_wr.en    = cfg.valid;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	obmt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	obmt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	obmt_back #(
		.READ_RECOVERY_TICKS (READ_RECOVERY_TICKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.pop_item  (pop_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.res       (res)
	);

endmodule
